>>> hw/rtl/sgpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpr_pkg
// Shared constants, register codes, control structs and the pan-law table
// generator for the stereo gain / pan / meter block.
// ----------------------------------------------------------------------------
package sgpr_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int MAX_BLOCK_DEF       = 4096;
  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Fixed field and state widths.
  localparam int LEN_W   = 13;
  localparam int GAIN_W  = 16;
  localparam int STATE_W = 32;
  localparam int COEF_W  = 17;
  localparam int DIV_W   = 33;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_TARGET_GAIN = 2'd0;
  localparam logic [1:0] REG_TARGET_PAN  = 2'd1;
  localparam logic [1:0] REG_MUTE        = 2'd2;

  // Register reset values.
  localparam logic [GAIN_W-1:0] TARGET_GAIN_RST = 16'd16384;
  localparam logic [GAIN_W-1:0] TARGET_PAN_RST  = 16'd0;

  // Unity gain in Q2.30.
  localparam logic [STATE_W-1:0] GAIN_UNITY = 32'h4000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted beat
    logic div_start;   // start a step division
    logic div_sel;     // 0: gain step, 1: pan step
    logic gain_wr;     // store the quotient as gain step
    logic pan_wr;      // store the quotient as pan step
    logic mul1;        // first multiply (magnitude by gain)
    logic mul2;        // second multiply (by pan coefficient)
    logic ch;          // 0: left, 1: right
    logic fin;         // finish the sample and load the result register
  } sgpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic blk_start;   // next beat opens a block
    logic div_done;    // quotient ready this cycle
  } sgpr_stat_t;

  // One entry of the quarter-sine table, Q1.15 capped at unity.
  function automatic logic [COEF_W-1:0] sine_entry(int unsigned i, int unsigned bits);
    logic [63:0] x;
    logic [63:0] z;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] q;
    x = 64'(i) << (30 - bits);
    z = (x * x) >> 30;
    p = 64'd172272;
    p = 64'd5027000 - ((p * z) >> 30);
    p = 64'd85569306 - ((p * z) >> 30);
    p = 64'd693598668 - ((p * z) >> 30);
    p = 64'd1686629713 - ((p * z) >> 30);
    s = (p * x) >> 30;
    q = (s + 64'd16384) >> 15;
    return (q > 64'd32768) ? 17'd32768 : q[COEF_W-1:0];
  endfunction

endpackage

>>> hw/rtl/sgpr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpr_if
// Stream channels of the block: the sample beat in and the mix beat out.
// ----------------------------------------------------------------------------
interface sgpr_in_if #(
  parameter int SB = sgpr_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SB-1:0]        left_sample;
  logic signed [SB-1:0]        right_sample;
  logic signed [SB-1:0]        bus_left;
  logic signed [SB-1:0]        bus_right;
  logic [sgpr_pkg::LEN_W-1:0]  block_len;

  modport source (output valid, left_sample, right_sample, bus_left, bus_right,
                  block_len, input ready);
  modport sink   (input valid, left_sample, right_sample, bus_left, bus_right,
                  block_len, output ready);
endinterface

interface sgpr_out_if #(
  parameter int SB = sgpr_pkg::SAMPLE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [SB-1:0] mix_left;
  logic signed [SB-1:0] mix_right;
  logic [SB-2:0]        in_peak_left;
  logic [SB-2:0]        in_peak_right;
  logic [SB-2:0]        in_peak_both;
  logic [SB-2:0]        out_peak_left;
  logic [SB-2:0]        out_peak_right;
  logic                 block_done;

  modport source (output valid, mix_left, mix_right, in_peak_left, in_peak_right,
                  in_peak_both, out_peak_left, out_peak_right, block_done,
                  input ready);
  modport sink   (input valid, mix_left, mix_right, in_peak_left, in_peak_right,
                  in_peak_both, out_peak_left, out_peak_right, block_done,
                  output ready);
endinterface

>>> hw/rtl/sgpr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpr_div
// Restoring divider, one quotient bit per cycle. Divides a signed ramp
// distance by the block length, truncating toward zero, and saturates the
// quotient to 32-bit signed.
// ----------------------------------------------------------------------------
module sgpr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sgpr_pkg::DIV_W-1:0]        dividend,
  input  logic                              neg,
  input  logic [sgpr_pkg::LEN_W-1:0]        divisor,
  output logic                              done,
  output logic signed [sgpr_pkg::STATE_W-1:0] quot
);

  localparam int DW = sgpr_pkg::DIV_W;
  localparam int LW = sgpr_pkg::LEN_W;
  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] quo;
  logic [LW-1:0] rem;
  logic [LW-1:0] div_r;
  logic          neg_r;

  logic [LW:0]   shifted;
  logic          ge;
  logic [LW:0]   diff;
  logic [DW:0]   q_s;

  // Trial subtraction of one step.
  assign shifted = {rem, quo[DW-1]};
  assign ge      = shifted >= {1'b0, div_r};
  assign diff    = shifted - {1'b0, div_r};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      div_r <= divisor;
      neg_r <= neg;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[LW-1:0] : shifted[LW-1:0];
    end
  end

  // Apply the sign and saturate to the 32-bit range.
  always_comb begin
    q_s = neg_r ? -{1'b0, quo} : {1'b0, quo};
    if (!neg_r && quo > DW'(32'h7FFF_FFFF)) begin
      quot = 32'sh7FFF_FFFF;
    end else if (neg_r && quo > DW'(32'h8000_0000)) begin
      quot = 32'sh8000_0000;
    end else begin
      quot = q_s[31:0];
    end
  end

endmodule

>>> hw/rtl/sgpr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpr_dp
// Datapath: ramp state, step divider, pan-law table, the shared multiplier
// stages, bus saturation, peak meters and the result register.
// ----------------------------------------------------------------------------
module sgpr_dp #(
  parameter int MAX_BLOCK       = sgpr_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS     = sgpr_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_BITS = sgpr_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sgpr_pkg::sgpr_cmd_t                cmd,
  output sgpr_pkg::sgpr_stat_t               stat,
  input  logic                               mute,
  input  logic [sgpr_pkg::GAIN_W-1:0]        target_gain,
  input  logic signed [sgpr_pkg::GAIN_W-1:0] target_pan,
  input  logic signed [SAMPLE_BITS-1:0]      left_sample,
  input  logic signed [SAMPLE_BITS-1:0]      right_sample,
  input  logic signed [SAMPLE_BITS-1:0]      bus_left,
  input  logic signed [SAMPLE_BITS-1:0]      bus_right,
  input  logic [sgpr_pkg::LEN_W-1:0]         block_len,
  output logic signed [SAMPLE_BITS-1:0]      mix_left,
  output logic signed [SAMPLE_BITS-1:0]      mix_right,
  output logic [SAMPLE_BITS-2:0]             in_peak_left,
  output logic [SAMPLE_BITS-2:0]             in_peak_right,
  output logic [SAMPLE_BITS-2:0]             in_peak_both,
  output logic [SAMPLE_BITS-2:0]             out_peak_left,
  output logic [SAMPLE_BITS-2:0]             out_peak_right,
  output logic                               block_done
);

  localparam int SB    = SAMPLE_BITS;
  localparam int STB   = SINE_TABLE_BITS;
  localparam int TAB_N = 1 << STB;
  localparam int IW    = STB + 1;
  localparam int LW    = sgpr_pkg::LEN_W;
  localparam int SW    = sgpr_pkg::STATE_W;
  localparam int CF    = sgpr_pkg::COEF_W;
  localparam int DW    = sgpr_pkg::DIV_W;
  localparam int TW    = SB + 3;    // gain-scaled magnitude
  localparam int MW    = SB + 5;    // pan-scaled magnitude
  localparam int P1W   = SB + 19;
  localparam int P2W   = SB + 20;
  localparam int EW    = SB + 6;    // mix sum
  localparam logic [SB-2:0] LIM = '1;
  localparam logic signed [EW-1:0] MIX_HI = EW'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [EW-1:0] MIX_LO = -MIX_HI - EW'(1);

  typedef logic [CF-1:0] tab_t [TAB_N+1];

  function automatic tab_t build_tab();
    tab_t t;
    for (int i = 0; i <= TAB_N; i++) begin
      t[i] = sgpr_pkg::sine_entry(i, STB);
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  // Input magnitude, clamped to full scale.
  function automatic logic [SB-2:0] in_mag(logic signed [SB-1:0] x);
    logic [SB-1:0] a;
    a = x[SB-1] ? (~x + 1'b1) : x;
    return (a > {1'b0, LIM}) ? LIM : a[SB-2:0];
  endfunction

  // Bus plus signed scaled magnitude, saturated.
  function automatic logic [SB-1:0] mix_sat(logic signed [SB-1:0] bus, logic neg,
                                            logic [MW-1:0] mag);
    logic signed [EW-1:0] b;
    logic signed [EW-1:0] m;
    logic signed [EW-1:0] s;
    b = EW'(bus);
    m = signed'(EW'(mag));
    s = neg ? (b - m) : (b + m);
    if (s > MIX_HI) begin
      return MIX_HI[SB-1:0];
    end else if (s < MIX_LO) begin
      return MIX_LO[SB-1:0];
    end
    return s[SB-1:0];
  endfunction

  // Captured beat.
  logic signed [SB-1:0] x_l, x_r, b_l, b_r;
  logic [LW-1:0]        len_c;

  // Ramp state.
  logic [SW-1:0]        gain_now, gain_ramp;
  logic signed [SW-1:0] pan_now, pan_ramp, gain_step, pan_step;
  logic [LW-1:0]        samples_left;

  // Multiplier stage registers.
  logic [TW-1:0]        t_r;
  logic [MW-1:0]        mag_l, mag_r;
  logic [CF-1:0]        rom_q;

  // Peaks.
  logic [SB-2:0] pk_in_l, pk_in_r, pk_in_b, pk_out_l, pk_out_r;

  // Divider hookup.
  logic                 div_done;
  logic signed [SW-1:0] div_q;
  logic signed [DW:0]   diff_g, diff_p, diff_sel;
  logic [DW-1:0]        div_mag;

  // Target values in Q2.30.
  logic signed [sgpr_pkg::GAIN_W-1:0] pan_cl;
  logic signed [SW-1:0]               pan_tq;
  logic [SW-1:0]                      gain_tq;

  // Pan-law index.
  logic [SW+1:0] u_sum;
  logic [SW+1:0] idx_raw;
  logic [IW-1:0] idx;
  logic [IW-1:0] rom_addr;

  // Multiply operands.
  logic signed [SB-1:0] x_sel;
  logic [SB-1:0]        a_sel;
  logic [P1W-1:0]       p1;
  logic [P2W-1:0]       p2;

  // Finish-stage values.
  logic [LW-1:0] sl_dec;
  logic          last;
  logic [SB-2:0] m_in_l, m_in_r, m_out_l, m_out_r;

  // Block length with out-of-range values folded in.
  always_comb begin
    if (block_len == '0) begin
      len_c = LW'(1);
    end else if (32'(block_len) > 32'(MAX_BLOCK)) begin
      len_c = LW'(MAX_BLOCK);
    end else begin
      len_c = block_len;
    end
  end

  // Clamped pan target and the gain target, both in Q2.30.
  always_comb begin
    if (target_pan < -16'sd16384) begin
      pan_cl = -16'sd16384;
    end else if (target_pan > 16'sd16384) begin
      pan_cl = 16'sd16384;
    end else begin
      pan_cl = target_pan;
    end
  end
  assign pan_tq  = {pan_cl, 16'd0};
  assign gain_tq = {target_gain, 16'd0};

  // Ramp distances fed to the divider as sign and magnitude.
  assign diff_g   = signed'({2'b00, gain_tq}) - signed'({2'b00, gain_now});
  assign diff_p   = (DW+1)'(pan_tq) - (DW+1)'(pan_now);
  assign diff_sel = cmd.div_sel ? diff_p : diff_g;
  assign div_mag  = diff_sel[DW] ? DW'(-diff_sel) : diff_sel[DW-1:0];

  sgpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_mag),
    .neg      (diff_sel[DW]),
    .divisor  (samples_left),
    .done     (div_done),
    .quot     (div_q)
  );

  assign stat.blk_start = (samples_left == '0);
  assign stat.div_done  = div_done;

  // Table index from the pan ramp, rounded and clamped to the table end.
  assign u_sum   = (SW+2)'(pan_ramp) + (SW+2)'(34'd1 << 30);
  assign idx_raw = (u_sum + ((SW+2)'(1) << (30 - STB))) >> (31 - STB);
  assign idx     = (idx_raw > (SW+2)'(TAB_N)) ? IW'(TAB_N) : idx_raw[IW-1:0];
  assign rom_addr = cmd.ch ? idx : (IW'(TAB_N) - idx);

  // Shared multiplier operands.
  assign x_sel = cmd.ch ? x_r : x_l;
  assign a_sel = x_sel[SB-1] ? (~x_sel + 1'b1) : x_sel;
  assign p1    = P1W'(a_sel) * P1W'(gain_ramp[SW-1:14]);
  assign p2    = P2W'(t_r) * P2W'(rom_q);

  // Finish-stage values.
  assign sl_dec  = samples_left - 1'b1;
  assign last    = (sl_dec == '0);
  assign m_in_l  = in_mag(x_l);
  assign m_in_r  = in_mag(x_r);
  assign m_out_l = (mag_l > MW'(LIM)) ? LIM : mag_l[SB-2:0];
  assign m_out_r = (mag_r > MW'(LIM)) ? LIM : mag_r[SB-2:0];

  // Captured beat and multiplier stages (payload, no reset).
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_l <= left_sample;
      x_r <= right_sample;
      b_l <= bus_left;
      b_r <= bus_right;
    end
    rom_q <= SINE_TAB[rom_addr];
    if (cmd.mul1) begin
      t_r <= TW'((p1 + (P1W'(1) << 15)) >> 16);
    end
    if (cmd.mul2) begin
      if (cmd.ch) begin
        mag_r <= MW'((p2 + (P2W'(1) << 14)) >> 15);
      end else begin
        mag_l <= MW'((p2 + (P2W'(1) << 14)) >> 15);
      end
    end
  end

  // Ramp state, block counter and meters.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_now     <= sgpr_pkg::GAIN_UNITY;
      pan_now      <= '0;
      gain_ramp    <= '0;
      pan_ramp     <= '0;
      gain_step    <= '0;
      pan_step     <= '0;
      samples_left <= '0;
      pk_in_l      <= '0;
      pk_in_r      <= '0;
      pk_in_b      <= '0;
      pk_out_l     <= '0;
      pk_out_r     <= '0;
    end else begin
      if (cmd.load && samples_left == '0) begin
        samples_left <= len_c;
        gain_ramp    <= gain_now;
        pan_ramp     <= pan_now;
      end
      if (cmd.gain_wr) begin
        gain_step <= div_q;
      end
      if (cmd.pan_wr) begin
        pan_step <= div_q;
      end
      if (cmd.fin) begin
        samples_left <= sl_dec;
        if (m_in_l > pk_in_l) begin
          pk_in_l <= m_in_l;
        end
        if (m_in_r > pk_in_r) begin
          pk_in_r <= m_in_r;
        end
        if (m_in_l > pk_in_b || m_in_r > pk_in_b) begin
          pk_in_b <= (m_in_l > m_in_r) ? m_in_l : m_in_r;
        end
        if (!mute) begin
          if (m_out_l > pk_out_l) begin
            pk_out_l <= m_out_l;
          end
          if (m_out_r > pk_out_r) begin
            pk_out_r <= m_out_r;
          end
          if (last) begin
            gain_now <= gain_tq;
            pan_now  <= pan_tq;
          end else begin
            gain_ramp <= gain_ramp + gain_step;
            pan_ramp  <= pan_ramp + pan_step;
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      mix_left   <= mute ? b_l : mix_sat(b_l, x_l[SB-1], mag_l);
      mix_right  <= mute ? b_r : mix_sat(b_r, x_r[SB-1], mag_r);
      block_done <= last;
    end
  end

  // The meter fields track the meters, which move only on a finish.
  assign in_peak_left   = pk_in_l;
  assign in_peak_right  = pk_in_r;
  assign in_peak_both   = pk_in_b;
  assign out_peak_left  = pk_out_l;
  assign out_peak_right = pk_out_r;

endmodule

>>> hw/rtl/sgpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpr_ctrl
// Controller: sequences step division at block start, the multiply steps of a
// sample (M1L, M2L, M1R, M2R) and the hand-over to the result register.
// ----------------------------------------------------------------------------
module sgpr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  mute,
  input  sgpr_pkg::sgpr_stat_t  stat,
  output sgpr_pkg::sgpr_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIVG   = 4'd1;
  localparam logic [3:0] S_WAITG  = 4'd2;
  localparam logic [3:0] S_DIVP   = 4'd3;
  localparam logic [3:0] S_WAITP  = 4'd4;
  localparam logic [3:0] S_M1L    = 4'd5;
  localparam logic [3:0] S_M2L    = 4'd6;
  localparam logic [3:0] S_M1R    = 4'd7;
  localparam logic [3:0] S_M2R    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state, state_next;
  logic       out_free;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (stat.blk_start) begin
            state_next = S_DIVG;
          end else begin
            state_next = mute ? S_FIN : S_M1L;
          end
        end
      end
      S_DIVG: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAITG;
      end
      S_WAITG: begin
        if (stat.div_done) begin
          cmd.gain_wr = 1'b1;
          state_next  = S_DIVP;
        end
      end
      S_DIVP: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = S_WAITP;
      end
      S_WAITP: begin
        cmd.div_sel = 1'b1;
        if (stat.div_done) begin
          cmd.pan_wr = 1'b1;
          state_next = mute ? S_FIN : S_M1L;
        end
      end
      S_M1L: begin
        cmd.mul1   = 1'b1;
        state_next = S_M2L;
      end
      S_M2L: begin
        cmd.mul2   = 1'b1;
        state_next = S_M1R;
      end
      S_M1R: begin
        cmd.mul1   = 1'b1;
        cmd.ch     = 1'b1;
        state_next = S_M2R;
      end
      S_M2R: begin
        cmd.mul2   = 1'b1;
        cmd.ch     = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/stereo_gain_pan_ramp_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_gain_pan_ramp_meter
// Stereo gain and constant-power pan with block-wise linear ramps, bus
// accumulation with saturation and held peak meters.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake       Carries
//  in_ch     sink       valid / ready   sample pair, bus pair, block length
//  out_ch    source     valid / ready   mix pair, five meters, block end flag
//  APB       slave      psel / penable  target_gain, target_pan, mute
//
// A sample passes from the capture cycle through the shared multiplier (first and
// second multiply for the left channel, then for the right) to the finish; when
// muted it goes from the capture cycle straight to the finish.
// The first sample of a block first runs the gain and pan step divisions on the
// one-bit-per-cycle divider.
// A new beat is taken once the previous sample has moved into the result
// register, so one finished beat may wait while the next is processed.
// Reset is synchronous; no clearing pass is needed.
//
module stereo_gain_pan_ramp_meter #(
  parameter int MAX_BLOCK       = sgpr_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS     = sgpr_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_BITS = sgpr_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  sgpr_in_if.sink                       in_ch,
  sgpr_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sgpr_pkg::ADDR_W-1:0]   paddr,
  input  logic [sgpr_pkg::DATA_W-1:0]   pwdata,
  output logic [sgpr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [sgpr_pkg::GAIN_W-1:0]        target_gain;
  logic signed [sgpr_pkg::GAIN_W-1:0] target_pan;
  logic                               mute;
  logic                               wr_en;

  sgpr_pkg::sgpr_cmd_t  cmd;
  sgpr_pkg::sgpr_stat_t stat;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_gain <= sgpr_pkg::TARGET_GAIN_RST;
      target_pan  <= sgpr_pkg::TARGET_PAN_RST;
      mute        <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        sgpr_pkg::REG_TARGET_GAIN: target_gain <= pwdata[15:0];
        sgpr_pkg::REG_TARGET_PAN:  target_pan  <= pwdata[15:0];
        sgpr_pkg::REG_MUTE:        mute        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      sgpr_pkg::REG_TARGET_GAIN: prdata = {16'd0, target_gain};
      sgpr_pkg::REG_TARGET_PAN:  prdata = 32'(target_pan);
      sgpr_pkg::REG_MUTE:        prdata = {31'd0, mute};
      default:                   prdata = '0;
    endcase
  end

  sgpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .mute      (mute),
    .stat      (stat),
    .cmd       (cmd)
  );

  sgpr_dp #(
    .MAX_BLOCK       (MAX_BLOCK),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .mute           (mute),
    .target_gain    (target_gain),
    .target_pan     (target_pan),
    .left_sample    (in_ch.left_sample),
    .right_sample   (in_ch.right_sample),
    .bus_left       (in_ch.bus_left),
    .bus_right      (in_ch.bus_right),
    .block_len      (in_ch.block_len),
    .mix_left       (out_ch.mix_left),
    .mix_right      (out_ch.mix_right),
    .in_peak_left   (out_ch.in_peak_left),
    .in_peak_right  (out_ch.in_peak_right),
    .in_peak_both   (out_ch.in_peak_both),
    .out_peak_left  (out_ch.out_peak_left),
    .out_peak_right (out_ch.out_peak_right),
    .block_done     (out_ch.block_done)
  );

`ifndef SYNTHESIS
  // One sample at a time: no beat is taken in the cycle after one is accepted.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("beat accepted while a sample is in work");

  // The combined input meter never trails either channel meter.
  a_peak_both: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.in_peak_both >= out_ch.in_peak_left &&
                      out_ch.in_peak_both >= out_ch.in_peak_right))
    else $error("combined input peak below a channel peak");

  // Step quotients are stored only when the divider reports completion.
  a_step_wr: assert property (@(posedge clk) disable iff (rst)
    (cmd.gain_wr || cmd.pan_wr) |-> stat.div_done)
    else $error("step written without a finished division");
`endif

endmodule
